>>> rtl/hmc_pkg.sv
package hmc_pkg;

	localparam int CODE_W         = 32;
	localparam int COORD_W        = 16;
	localparam int LVL_W          = 5;
	localparam int REMAP_W        = 8;
	localparam int COORD_BITS_DEF = 16;
	localparam int LVLS_PER_STAGE = 4;

	localparam logic [REMAP_W-1:0] REMAP_INIT = 8'hb4;
	localparam logic [31:0]        M2H_FLIP   = 32'h8200_0028;
	localparam logic [31:0]        H2M_FLIP   = 32'h3300_00cc;

	typedef enum logic [2:0] {
		OP_M2H  = 3'd0,
		OP_H2M  = 3'd1,
		OP_XY2M = 3'd2,
		OP_M2XY = 3'd3,
		OP_H2XY = 3'd4
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CODE_W-1:0]  code;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [LVL_W-1:0]   levels;
		logic [REMAP_W-1:0] remap;
		logic [CODE_W-1:0]  acc;
	} hmc_item_t;

	// returns {next remap, mapped quadrant}
	function automatic logic [REMAP_W+1:0] walk_step(input logic [REMAP_W-1:0] remap,
			input logic [1:0] quad, input logic dir);
		logic [1:0]  mapped;
		logic [1:0]  sel;
		logic [31:0] flip;
		mapped = remap[{quad, 1'b0} +: 2];
		sel    = dir ? quad : mapped;
		flip   = dir ? H2M_FLIP : M2H_FLIP;
		return {remap ^ flip[{sel, 3'b000} +: REMAP_W], mapped};
	endfunction

	function automatic logic [CODE_W-1:0] interleave(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		logic [CODE_W-1:0] r;
		r = '0;
		for (int i = 0; i < COORD_W; i++) begin
			r[2*i]   = x[i];
			r[2*i+1] = y[i];
		end
		return r;
	endfunction

	// returns {y, x}
	function automatic logic [2*COORD_W-1:0] deinterleave(input logic [CODE_W-1:0] code);
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
		for (int i = 0; i < COORD_W; i++) begin
			a[i] = code[2*i];
			b[i] = code[2*i+1];
		end
		return {b, a};
	endfunction

endpackage

>>> rtl/hmc_walk_stage.sv
module hmc_walk_stage #(
	parameter int FIRST_LV = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hmc_pkg::hmc_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output hmc_pkg::hmc_item_t out_item
);
	import hmc_pkg::*;

	localparam int NLV = LVLS_PER_STAGE;

	logic [REMAP_W-1:0] remap_w [NLV+1];
	logic [CODE_W-1:0]  acc_w   [NLV+1];
	logic               dir;
	hmc_item_t          nxt;
	logic               vld_s1;
	hmc_item_t          item_s1;

	assign dir        = (in_item.op != OP_M2H);
	assign remap_w[0] = in_item.remap;
	assign acc_w[0]   = in_item.acc;

	for (genvar k = 0; k < NLV; k++) begin : g_lv
		localparam int LV = FIRST_LV - k;
		if (LV >= 1) begin : g_act
			logic                act;
			logic [REMAP_W+1:0]  step;
			assign act  = (in_item.levels >= LVL_W'(LV));
			assign step = walk_step(remap_w[k], in_item.code[2*LV-1 -: 2], dir);
			assign remap_w[k+1] = act ? step[REMAP_W+1:2] : remap_w[k];
			assign acc_w[k+1]   = act ? (acc_w[k] | (CODE_W'(step[1:0]) << (2*LV-2)))
				: acc_w[k];
		end else begin : g_idle
			assign remap_w[k+1] = remap_w[k];
			assign acc_w[k+1]   = acc_w[k];
		end
	end

	always_comb begin
		nxt       = in_item;
		nxt.remap = remap_w[NLV];
		nxt.acc   = acc_w[NLV];
	end

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			item_s1 <= nxt;
		end
	end

endmodule

>>> rtl/hmc_out_stage.sv
module hmc_out_stage #(
	parameter int COORD_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  hmc_pkg::hmc_item_t         in_item,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [hmc_pkg::CODE_W+2*hmc_pkg::COORD_W-1:0] m_axis_tdata
);
	import hmc_pkg::*;

	localparam logic [COORD_W-1:0] CMASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [CODE_W-1:0]  KMASK = CODE_W'((64'd1 << (2*COORD_BITS)) - 64'd1);

	logic [CODE_W-1:0]    code_res;
	logic [2*COORD_W-1:0] xy_res;
	logic                 vld_s1;
	logic [CODE_W+2*COORD_W-1:0] res_s1;

	always_comb begin
		code_res = '0;
		xy_res   = '0;
		case (in_item.op)
			OP_M2H, OP_H2M: code_res = in_item.acc;
			OP_XY2M:        code_res = interleave(in_item.x & CMASK, in_item.y & CMASK);
			OP_M2XY:        xy_res   = deinterleave(in_item.code & KMASK);
			OP_H2XY:        xy_res   = deinterleave(in_item.acc);
			default: begin
				code_res = '0;
				xy_res   = '0;
			end
		endcase
	end

	assign in_ready      = !vld_s1 || m_axis_tready;
	assign m_axis_tvalid = vld_s1;
	assign m_axis_tdata  = res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			res_s1 <= {xy_res, code_res};
		end
	end

	a_high_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ((res_s1[CODE_W-1:0] & ~KMASK) == '0))
		else $error("code bits above the curve order are set");

	a_xy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ((res_s1[CODE_W +: COORD_W] & ~CMASK) == '0)
			&& ((res_s1[CODE_W+COORD_W +: COORD_W] & ~CMASK) == '0))
		else $error("coordinate bits above the curve order are set");

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && in_valid |=> vld_s1)
		else $error("accepted item lost at the output register");

endmodule

>>> rtl/hilbert_morton_code_converter.sv
// Converts between 2D Hilbert codes, Morton codes and x/y coordinates, one item per clock.
// From s_axis to m_axis an item passes one input register, WALK_STAGES walk registers (one
// per four curve levels of the top-down remap walk, COORD_BITS / 4 rounded up) and one output
// register. A new item may enter every cycle; m_axis_tready low stalls the pipe stage by
// stage, so free stages keep taking items. order_bits may only be written while no item is in
// flight and is sampled when an item enters; values above COORD_BITS act as COORD_BITS.
module hilbert_morton_code_converter #(
	parameter int COORD_BITS = hmc_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            order_bits_we,
	input  logic [hmc_pkg::LVL_W-1:0]       order_bits_wdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// code_in[31:0], x_in[47:32], y_in[63:48]
	input  logic [hmc_pkg::CODE_W+2*hmc_pkg::COORD_W-1:0] s_axis_tdata,
	// op[2:0]
	input  logic [2:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// code_out[31:0], x_out[47:32], y_out[63:48]
	output logic [hmc_pkg::CODE_W+2*hmc_pkg::COORD_W-1:0] m_axis_tdata
);
	import hmc_pkg::*;

	localparam int WALK_STAGES = (COORD_BITS + LVLS_PER_STAGE - 1) / LVLS_PER_STAGE;
	localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(COORD_BITS);

	logic [LVL_W-1:0] order_bits_q;
	logic [LVL_W-1:0] lvl_sat;
	hmc_item_t        in_item;
	logic             vld_s1;
	hmc_item_t        item_s1;

	logic      vld_w  [WALK_STAGES+1];
	logic      rdy_w  [WALK_STAGES+1];
	hmc_item_t item_w [WALK_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_bits_q <= LVL_W'(16);
		end else if (order_bits_we) begin
			order_bits_q <= order_bits_wdata;
		end
	end

	assign lvl_sat = (order_bits_q > MAX_LVL) ? MAX_LVL : order_bits_q;

	always_comb begin
		in_item.op     = op_t'(s_axis_tuser);
		in_item.code   = s_axis_tdata[CODE_W-1:0];
		in_item.x      = s_axis_tdata[CODE_W +: COORD_W];
		in_item.y      = s_axis_tdata[CODE_W+COORD_W +: COORD_W];
		in_item.levels = (op_t'(s_axis_tuser) == OP_H2XY) ? MAX_LVL : lvl_sat;
		in_item.remap  = REMAP_INIT;
		in_item.acc    = '0;
	end

	assign s_axis_tready = !vld_s1 || rdy_w[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			item_s1 <= in_item;
		end
	end

	assign vld_w[0]  = vld_s1;
	assign item_w[0] = item_s1;

	for (genvar g = 0; g < WALK_STAGES; g++) begin : g_walk
		hmc_walk_stage #(
			.FIRST_LV(COORD_BITS - g*LVLS_PER_STAGE)
		) u_walk (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld_w[g]),
			.in_ready (rdy_w[g]),
			.in_item  (item_w[g]),
			.out_valid(vld_w[g+1]),
			.out_ready(rdy_w[g+1]),
			.out_item (item_w[g+1])
		);
	end

	hmc_out_stage #(
		.COORD_BITS(COORD_BITS)
	) u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (vld_w[WALK_STAGES]),
		.in_ready     (rdy_w[WALK_STAGES]),
		.in_item      (item_w[WALK_STAGES]),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while the output drains");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !rdy_w[0] |=> vld_s1 && $stable(item_s1))
		else $error("input stage changed under a stall");

	a_levels_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> item_s1.levels <= MAX_LVL)
		else $error("level count above the curve order");

endmodule
